@@ hdl/mcpg_pkg.sv @@
// Package for the midpoint circle point generator.
// Holds the item kind codes, batch sizing and queue sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package mcpg_pkg;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  localparam int BATCH_POINTS = 8;
  localparam int IDX_W        = $clog2(BATCH_POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BATCH_POINTS - 1);

  localparam int QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic push_valid;
    logic push_ready;
  } queue_wr_t;

  typedef struct packed {
    logic pop_valid;
  } queue_rd_t;

endpackage

@@ hdl/mcpg_if.sv @@
// Channel interfaces of the midpoint circle point generator.
// Valid/ready handshake with source and sink modports; no dependencies.
`timescale 1ns / 1ps

interface mcpg_in_if #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) ();
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [COORD_BITS-1:0]  center_x;
  logic signed [COORD_BITS-1:0]  center_y;
  logic        [RADIUS_BITS-1:0] radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

interface mcpg_out_if #(
  parameter int POINT_BITS = 13
) ();
  logic                         valid;
  logic                         ready;
  logic signed [POINT_BITS-1:0] point_x;
  logic signed [POINT_BITS-1:0] point_y;
  logic                         last;
  logic                         done_res;

  modport source (output valid, point_x, point_y, last, done_res, input ready);
  modport sink   (input valid, point_x, point_y, last, done_res, output ready);
endinterface

@@ hdl/mcpg_front.sv @@
// Front end: accepts start/step items, runs one midpoint iteration per step
// and pushes a batch descriptor into the queue. Depends on mcpg_pkg, mcpg_if.
`timescale 1ns / 1ps

module mcpg_front #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10,
  parameter int DESC_W      = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  mcpg_in_if.sink             in_ch,
  output mcpg_pkg::queue_wr_t q_wr,
  input  logic                q_ready,
  output logic [DESC_W-1:0]   q_data
);

  localparam int SW = RADIUS_BITS + 2;
  localparam int DW = RADIUS_BITS + 4;

  logic signed [COORD_BITS-1:0] cx_r, cx_nxt;
  logic signed [COORD_BITS-1:0] cy_r, cy_nxt;
  logic signed [SW-1:0]         x_r, x_nxt;
  logic signed [SW-1:0]         y_r, y_nxt;
  logic signed [DW-1:0]         dec_r, dec_nxt;
  logic                         running_r, running_nxt;

  logic                         accept;
  logic                         is_start;
  logic signed [SW-1:0]         x_step;
  logic signed [SW-1:0]         y_step;
  logic signed [DW-1:0]         dec_step;
  logic signed [DW-1:0]         x2;
  logic signed [DW-1:0]         y2;
  logic                         step_done;
  logic signed [SW-1:0]         r_ext;
  logic signed [SW-1:0]         push_x;
  logic signed [SW-1:0]         push_y;
  logic                         push_done;

  assign in_ch.ready     = q_ready;
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_start = (in_ch.kind == mcpg_pkg::KIND_START);
  assign r_ext    = SW'({1'b0, in_ch.radius});

  always_comb begin
    x_step = x_r + SW'(1);
    y_step = dec_r[DW-1] ? y_r : (y_r - SW'(1));
    x2 = DW'({{(DW-SW){x_step[SW-1]}}, x_step, 1'b0} >> 1) <<< 1;
    y2 = DW'({{(DW-SW){y_step[SW-1]}}, y_step, 1'b0} >> 1) <<< 1;
    if (dec_r[DW-1]) begin
      dec_step = dec_r + x2 + DW'(1);
    end else begin
      dec_step = dec_r + x2 + DW'(1) - y2;
    end
    step_done = x_step > y_step;
  end

  always_comb begin
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    dec_nxt     = dec_r;
    running_nxt = running_r;
    push_x      = x_step;
    push_y      = y_step;
    push_done   = step_done;
    q_wr.push_ready = q_ready;
    q_wr.push_valid = 1'b0;
    if (accept) begin
      if (is_start) begin
        cx_nxt      = in_ch.center_x;
        cy_nxt      = in_ch.center_y;
        x_nxt       = '0;
        y_nxt       = r_ext;
        dec_nxt     = DW'(1) - DW'({1'b0, in_ch.radius});
        running_nxt = 1'b1;
        push_x      = '0;
        push_y      = r_ext;
        push_done   = 1'b0;
        q_wr.push_valid = 1'b1;
      end else if (running_r) begin
        x_nxt       = x_step;
        y_nxt       = y_step;
        dec_nxt     = dec_step;
        running_nxt = !step_done;
        q_wr.push_valid = 1'b1;
      end
    end
  end

  assign q_data = is_start ? {push_done, push_y, push_x, in_ch.center_y, in_ch.center_x}
                           : {push_done, push_y, push_x, cy_r, cx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r      <= '0;
      cy_r      <= '0;
      x_r       <= '0;
      y_r       <= '0;
      dec_r     <= '0;
      running_r <= 1'b0;
    end else begin
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      dec_r     <= dec_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

@@ hdl/mcpg_queue.sv @@
// Short batch descriptor queue between front and back end.
// Register based, one push (if not full) and one pop (if not empty) per cycle. Depends on mcpg_pkg.
`timescale 1ns / 1ps

module mcpg_queue #(
  parameter int WIDTH = 61
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                not_full,
  input  logic [WIDTH-1:0]    wr_data,
  output mcpg_pkg::queue_rd_t q_rd,
  output logic [WIDTH-1:0]    rd_data,
  input  logic                pop
);

  localparam int DEPTH = mcpg_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign not_full       = (count_r != CW'(DEPTH));
  assign q_rd.pop_valid = (count_r != '0);
  assign rd_data        = mem_r[rptr_r];
  assign do_push        = push && not_full;
  assign do_pop         = pop && q_rd.pop_valid;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

@@ hdl/mcpg_back.sv @@
// Back end: expands one batch descriptor into eight mirrored points, one per
// cycle while the output is not stalled, through a registered output stage. Depends on mcpg_pkg, mcpg_if.
`timescale 1ns / 1ps

module mcpg_back #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10,
  parameter int DESC_W      = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mcpg_pkg::queue_rd_t q_rd,
  input  logic [DESC_W-1:0]   q_data,
  output logic                q_pop,
  mcpg_out_if.source          out_ch
);

  localparam int SW = RADIUS_BITS + 2;
  localparam int PW = COORD_BITS + 1;
  localparam int AW = ((COORD_BITS > SW) ? COORD_BITS : SW) + 1;
  localparam int IW = mcpg_pkg::IDX_W;

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic signed [SW-1:0]         x_r, y_r;
  logic                         done_r;
  logic                         work_valid_r, work_valid_nxt;
  logic [IW-1:0]                idx_r, idx_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic signed [PW-1:0]         px_r, py_r;
  logic                         last_r;
  logic                         done_out_r;

  logic                         load_out;
  logic                         at_last;
  logic                         x_use_y;
  logic                         x_neg;
  logic                         y_neg;
  logic signed [AW-1:0]         cx_w, cy_w, sx_w, sy_w, ox_w, oy_w;
  logic signed [AW-1:0]         sum_x, sum_y;

  assign at_last  = (idx_r == mcpg_pkg::LAST_IDX);
  assign load_out = work_valid_r && (!out_valid_r || out_ch.ready);
  assign q_pop    = q_rd.pop_valid && (!work_valid_r || (load_out && at_last));

  always_comb begin
    x_use_y = idx_r[0] ^ idx_r[1];
    x_neg   = idx_r[1] ^ idx_r[2];
    y_neg   = idx_r[2];
    cx_w = AW'({{(AW-COORD_BITS){cx_r[COORD_BITS-1]}}, cx_r});
    cy_w = AW'({{(AW-COORD_BITS){cy_r[COORD_BITS-1]}}, cy_r});
    sx_w = AW'({{(AW-SW){x_r[SW-1]}}, x_r});
    sy_w = AW'({{(AW-SW){y_r[SW-1]}}, y_r});
    ox_w = x_use_y ? sy_w : sx_w;
    oy_w = x_use_y ? sx_w : sy_w;
    sum_x = x_neg ? (cx_w - ox_w) : (cx_w + ox_w);
    sum_y = y_neg ? (cy_w - oy_w) : (cy_w + oy_w);
  end

  always_comb begin
    work_valid_nxt = work_valid_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + IW'(1);
      if (at_last) begin
        work_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      work_valid_nxt = 1'b1;
      idx_nxt        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx_r   <= q_data[COORD_BITS-1:0];
      cy_r   <= q_data[2*COORD_BITS-1:COORD_BITS];
      x_r    <= q_data[2*COORD_BITS+SW-1:2*COORD_BITS];
      y_r    <= q_data[2*COORD_BITS+2*SW-1:2*COORD_BITS+SW];
      done_r <= q_data[DESC_W-1];
    end
    if (load_out) begin
      px_r       <= sum_x[PW-1:0];
      py_r       <= sum_y[PW-1:0];
      last_r     <= at_last;
      done_out_r <= done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.point_x  = px_r;
  assign out_ch.point_y  = py_r;
  assign out_ch.last     = last_r;
  assign out_ch.done_res = done_out_r;

endmodule

@@ hdl/midpoint_circle_point_generator_top.sv @@
// Top level of the midpoint circle point generator.
// Instantiates front end, descriptor queue and back end; uses mcpg_pkg, mcpg_if.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   kind, center_x, center_y, radius
//   out_ch   out  valid/ready   point_x, point_y, last, done_res
//
// A start or step item is accepted while the descriptor queue has room; its
// batch of eight points leaves at one point per cycle while the output is
// not stalled, through the single point adder pair in the back end.
// Steps with no circle active emit nothing. Reset clears all control state.
// Input stalls only when the two-entry descriptor queue is full; output
// stalls hold the output register and the current point index.
`timescale 1ns / 1ps

module midpoint_circle_point_generator_top #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  mcpg_in_if.sink    in_ch,
  mcpg_out_if.source out_ch
);

  localparam int DESC_W = 2 * COORD_BITS + 2 * (RADIUS_BITS + 2) + 1;

  mcpg_pkg::queue_wr_t q_wr;
  mcpg_pkg::queue_rd_t q_rd;
  logic                q_not_full;
  logic                q_pop;
  logic [DESC_W-1:0]   wr_desc;
  logic [DESC_W-1:0]   rd_desc;

  mcpg_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .DESC_W      (DESC_W)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_wr    (q_wr),
    .q_ready (q_not_full),
    .q_data  (wr_desc)
  );

  mcpg_queue #(
    .WIDTH (DESC_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_wr.push_valid && q_wr.push_ready),
    .not_full (q_not_full),
    .wr_data  (wr_desc),
    .q_rd     (q_rd),
    .rd_data  (rd_desc),
    .pop      (q_pop)
  );

  mcpg_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS),
    .DESC_W      (DESC_W)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_data (rd_desc),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

@@ sim/mcpg_point_checker.sv @@
// Point checker for the midpoint circle point generator: predicts each batch of
// mirrored circle points from the input transfers and compares the output stream.
// Depends on mcpg_pkg and the channel interfaces in mcpg_if.
`timescale 1ns / 1ps

module mcpg_point_checker (
  input  logic       clk,
  input  logic       rst_n,
  mcpg_in_if         in_ch,
  mcpg_out_if        out_ch,
  output int         fail_count,
  output int         pending,
  output int         circles_started,
  output int         circles_finished,
  output int         empty_steps,
  output int         points_checked
);

  localparam int PT_W = 13;

  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   last;
    logic                   done_flag;
  } circle_pt_t;

  circle_pt_t expected_pts[$];

  int held_cx;
  int held_cy;
  int sx;
  int sy;
  int dec;
  bit active;
  int errors;
  int starts;
  int finished;
  int idle_steps;
  int checked;

  initial begin
    errors           = 0;
    starts           = 0;
    finished         = 0;
    idle_steps       = 0;
    checked          = 0;
  end

  function automatic void push_batch(input bit fin);
    int         ox[8];
    int         oy[8];
    circle_pt_t p;
    ox = '{sx, sy, -sy, -sx, -sx, -sy, sy, sx};
    oy = '{sy, sx, sx, sy, -sy, -sx, -sx, -sy};
    for (int k = 0; k < mcpg_pkg::BATCH_POINTS; k++) begin
      p.px        = PT_W'(held_cx + ox[k]);
      p.py        = PT_W'(held_cy + oy[k]);
      p.last      = (k == mcpg_pkg::BATCH_POINTS - 1);
      p.done_flag = fin;
      expected_pts.push_back(p);
    end
  endfunction

  task automatic advance_circle(input mcpg_pkg::kind_t kind, input logic signed [11:0] cx,
                                input logic signed [11:0] cy, input logic [9:0] r);
    bit fin;
    if (kind == mcpg_pkg::KIND_START) begin
      held_cx = cx;
      held_cy = cy;
      dec     = 1 - int'(r);
      sx      = 0;
      sy      = int'(r);
      active  = 1'b1;
      starts++;
      push_batch(1'b0);
    end else if (!active || sx > sy) begin
      active = 1'b0;
      idle_steps++;
    end else begin
      sx = sx + 1;
      if (dec < 0) begin
        dec = dec + 2 * sx + 1;
      end else begin
        sy  = sy - 1;
        dec = dec + 2 * sx + 1 - 2 * sy;
      end
      fin = (sx > sy);
      if (fin) begin
        active = 1'b0;
        finished++;
      end
      push_batch(fin);
    end
  endtask

  task automatic check_point();
    circle_pt_t want;
    if (expected_pts.size() == 0) begin
      $error("unexpected point: point_x %0d point_y %0d last %0b done_res %0b",
             out_ch.point_x, out_ch.point_y, out_ch.last, out_ch.done_res);
      errors++;
    end else begin
      want = expected_pts.pop_front();
      checked++;
      if (out_ch.point_x !== want.px) begin
        $error("point_x mismatch: expected %0d, actual %0d", $signed(want.px), out_ch.point_x);
        errors++;
      end
      if (out_ch.point_y !== want.py) begin
        $error("point_y mismatch: expected %0d, actual %0d", $signed(want.py), out_ch.point_y);
        errors++;
      end
      if (out_ch.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, out_ch.last);
        errors++;
      end
      if (out_ch.done_res !== want.done_flag) begin
        $error("done_res mismatch: expected %0b, actual %0b", want.done_flag, out_ch.done_res);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_cx = 0;
      held_cy = 0;
      sx      = 0;
      sy      = 0;
      dec     = 0;
      active  = 1'b0;
      expected_pts.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_circle(mcpg_pkg::kind_t'(in_ch.kind), in_ch.center_x, in_ch.center_y,
                       in_ch.radius);
      end
      if (out_ch.valid && out_ch.ready) begin
        check_point();
      end
    end
    fail_count       <= errors;
    pending          <= expected_pts.size();
    circles_started  <= starts;
    circles_finished <= finished;
    empty_steps      <= idle_steps;
    points_checked   <= checked;
  end

endmodule

@@ sim/midpoint_circle_point_generator_top_tb.sv @@
// Testbench top for the midpoint circle point generator: drives start and step
// transfers in bursts, stalls the point output, and reports the verdict.
// Depends on mcpg_pkg, mcpg_if, the generator RTL and mcpg_point_checker.
`timescale 1ns / 1ps

module midpoint_circle_point_generator_top_tb;

  localparam int TOTAL_ITEMS  = 220;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {
    RX_FLOW,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  logic clk;
  logic rst_n;

  mcpg_in_if  #(.COORD_BITS(12), .RADIUS_BITS(10)) in_ch();
  mcpg_out_if #(.POINT_BITS(13))                   out_ch();

  int fail_count;
  int pending;
  int circles_started;
  int circles_finished;
  int empty_steps;
  int points_checked;

  int items_sent;
  int burst_left;
  bit hold_req;
  bit hold_over;

  midpoint_circle_point_generator_top #(
    .COORD_BITS (12),
    .RADIUS_BITS(10)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  mcpg_point_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending         (pending),
    .circles_started (circles_started),
    .circles_finished(circles_finished),
    .empty_steps     (empty_steps),
    .points_checked  (points_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input mcpg_pkg::kind_t kind, input logic signed [11:0] cx,
                           input logic signed [11:0] cy, input logic [9:0] r);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= kind;
    in_ch.center_x <= cx;
    in_ch.center_y <= cy;
    in_ch.radius   <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_step();
    send_item(mcpg_pkg::KIND_STEP, 12'($urandom), 12'($urandom), 10'($urandom));
  endtask

  task automatic send_steps(input int n);
    repeat (n) send_step();
  endtask

  // receiver: stall pattern of its own, plus one long hold-off on request
  initial begin
    rx_mode_t mode;
    int       span;
    int       hold_cnt;
    mode         = RX_FLOW;
    span         = 0;
    hold_cnt     = 0;
    hold_over    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_over) begin
        out_ch.ready <= 1'b0;
        hold_cnt++;
        if (hold_cnt == HOLD_CYCLES) hold_over = 1'b1;
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(4, 60);
        end
        span--;
        case (mode)
          RX_FLOW:   out_ch.ready <= 1'b1;
          RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog: end the run after a long stretch with no transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("midpoint_circle_point_generator_top_tb failed");
    $finish;
  end

  initial begin
    logic [9:0] r;
    int         nsteps;
    int         pick;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.kind     = mcpg_pkg::KIND_START;
    in_ch.center_x = '0;
    in_ch.center_y = '0;
    in_ch.radius   = '0;
    hold_req       = 1'b0;
    items_sent     = 0;
    burst_left     = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // step with no circle active
    send_item(mcpg_pkg::KIND_STEP, 12'sh800, 12'sh7FF, 10'h3FF);
    // zero radius at the negative corner, then the crossing step, then a dead step
    send_item(mcpg_pkg::KIND_START, -12'sd2048, -12'sd2048, 10'd0);
    send_steps(2);
    // largest radius at the positive corner, abandoned by a new start
    send_item(mcpg_pkg::KIND_START, 12'sd2047, 12'sd2047, 10'd1023);
    send_steps(3);
    send_item(mcpg_pkg::KIND_START, 12'sd2047, -12'sd2048, 10'd1023);
    send_steps(2);
    send_item(mcpg_pkg::KIND_START, -12'sd2048, 12'sd2047, 10'd512);
    send_step();
    // small circles run to the end and one past it
    send_item(mcpg_pkg::KIND_START, 12'sd0, 12'sd0, 10'd1);
    send_steps(2);
    send_item(mcpg_pkg::KIND_START, -12'sd5, 12'sd7, 10'd3);
    send_steps(4);

    hold_req <= 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) r = 10'($urandom_range(900, 1023));
      else if (pick < 4) r = 10'($urandom_range(13, 60));
      else r = 10'($urandom_range(0, 12));
      send_item(mcpg_pkg::KIND_START, 12'($urandom), 12'($urandom), r);
      pick = $urandom_range(0, 9);
      if (r > 100) nsteps = $urandom_range(3, 10);
      else if (pick < 7) nsteps = (int'(r) * 71) / 100 + $urandom_range(1, 3);
      else if (pick < 9) nsteps = $urandom_range(0, int'(r) / 2);
      else nsteps = $urandom_range(1, 3);
      send_steps(nsteps);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d input transfers: %0d circles started, %0d run to the end,",
             items_sent, circles_started, circles_finished);
    $display("%0d steps with no circle active, %0d points checked.",
             empty_steps, points_checked);
    if (fail_count == 0) begin
      $display("midpoint_circle_point_generator_top_tb passed");
    end else begin
      $display("midpoint_circle_point_generator_top_tb failed");
    end
    $finish;
  end

endmodule
